/* design/upe_pkg.sv */
package upe_pkg;

    // Character codes
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_SLASH = 8'h2f;
    localparam logic [7:0] C_QUES  = 8'h3f;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_TILDE = 8'h7e;
    localparam logic [7:0] C_TWO   = 8'h32;
    localparam logic [7:0] C_FIVE  = 8'h35;

    // Component kinds
    localparam logic [1:0] KIND_PATH  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_FRAG  = 2'd2;

    // Held escape states
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    // One item expands to at most seven bytes
    localparam int LIST_DEPTH = 7;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int SEG_NUM    = 4;

    // Up to three bytes from one raw byte
    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
        logic            hold;
    } t_seg;

    // Expanded item handed to the output side
    typedef struct packed {
        logic                       load;
        logic [LIST_DEPTH-1:0][7:0] bytes;
        logic [CNT_W-1:0]           cnt;
        logic                       comp_last;
    } t_list;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        case (c) inside
            [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic passes(input logic [7:0] c, input logic qf);
        logic r;
        case (c) inside
            [8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]: r = 1'b1;
            8'h2d, 8'h2e, 8'h5f, C_TILDE: r = 1'b1;
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29: r = 1'b1;
            8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h3a, 8'h40: r = 1'b1;
            C_SLASH, C_QUES: r = qf;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'h0, n};
        end else begin
            r = 8'h57 + {4'h0, n};
        end
        return r;
    endfunction

    function automatic t_seg seg_one(input logic [7:0] c);
        t_seg s;
        s      = '0;
        s.b[0] = c;
        s.n    = 2'd1;
        return s;
    endfunction

    // Escaped percent sign
    function automatic t_seg seg_pct();
        t_seg s;
        s.b[0] = C_PCT;
        s.b[1] = C_TWO;
        s.b[2] = C_FIVE;
        s.n    = 2'd3;
        s.hold = 1'b0;
        return s;
    endfunction

    // One byte with nothing held: pass, hold a percent sign, or escape
    function automatic t_seg plain_op(input logic [7:0] c, input logic qf);
        t_seg s;
        s = '0;
        if (passes(c, qf)) begin
            s = seg_one(c);
        end else if (c == C_PCT) begin
            s.hold = 1'b1;
        end else begin
            s.b[0] = C_PCT;
            s.b[1] = hex_char(c[7:4]);
            s.b[2] = hex_char(c[3:0]);
            s.n    = 2'd3;
        end
        return s;
    endfunction

endpackage

/* design/upe_encode.sv */
module upe_encode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_component_kind,
    input  logic          i_free,
    output upe_pkg::t_list o_list
);
    import upe_pkg::*;

    logic       r_a_vld, n_a_vld;
    logic [7:0] r_a_byte;
    logic       r_a_last;
    logic [1:0] r_kind;
    logic       r_at_start, n_at_start;
    logic [1:0] r_hc, n_hc;
    logic [7:0] r_hd, n_hd;

    logic       a_move;
    logic       accept;
    logic       qf;
    logic [7:0] ident;
    t_seg       p_c;
    t_seg       p_d;
    t_seg [SEG_NUM-1:0] seg;
    logic [1:0] hc_in;
    logic [1:0] hc_mid;
    logic [LIST_DEPTH-1:0][7:0] l_b;
    logic [CNT_W-1:0] l_n;

    // Hand over the held word once the output side can take its bytes
    assign a_move  = r_a_vld && i_free;
    assign o_stall = r_a_vld && !i_free;
    assign accept  = i_valid && !o_stall;

    assign qf  = (r_kind == KIND_QUERY) || (r_kind == KIND_FRAG);
    assign p_c = plain_op(r_a_byte, qf);
    assign p_d = plain_op(r_hd, qf);

    always_comb begin
        unique case (r_kind)
            KIND_QUERY: ident = C_QUES;
            KIND_FRAG:  ident = C_HASH;
            default:    ident = C_SLASH;
        endcase
    end

    // Build the byte segments for the held word
    always_comb begin
        seg    = '0;
        hc_in  = r_at_start ? HELD_NONE : r_hc;
        hc_mid = HELD_NONE;
        n_hd   = r_hd;
        if (r_at_start && !r_a_last && r_a_byte == ident) begin
            seg[0] = seg_one(r_a_byte);
        end else begin
            case (hc_in)
                HELD_PCT: begin
                    if (is_hex(r_a_byte)) begin
                        n_hd   = r_a_byte;
                        hc_mid = HELD_DIGIT;
                    end else begin
                        seg[0] = seg_pct();
                        seg[1] = p_c;
                        hc_mid = p_c.hold ? HELD_PCT : HELD_NONE;
                    end
                end
                HELD_DIGIT: begin
                    if (is_hex(r_a_byte)) begin
                        seg[0].b[0] = C_PCT;
                        seg[0].b[1] = r_hd;
                        seg[0].b[2] = r_a_byte;
                        seg[0].n    = 2'd3;
                    end else begin
                        seg[0] = seg_pct();
                        seg[1] = p_d;
                        seg[2] = p_c;
                        hc_mid = p_c.hold ? HELD_PCT : HELD_NONE;
                    end
                end
                default: begin
                    seg[0] = p_c;
                    hc_mid = p_c.hold ? HELD_PCT : HELD_NONE;
                end
            endcase
        end
        // Flush held bytes at the end of the component
        if (r_a_last) begin
            if (hc_mid == HELD_PCT) begin
                seg[3] = seg_pct();
            end else if (hc_mid == HELD_DIGIT) begin
                seg[2] = seg_pct();
                seg[3] = seg_one(n_hd);
            end
        end
    end

    // Pack the segments into one byte list
    always_comb begin
        l_b = '0;
        l_n = '0;
        for (int i = 0; i < SEG_NUM; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (j < int'(seg[i].n)) begin
                    l_b[l_n[IDX_W-1:0]] = seg[i].b[j];
                    l_n = l_n + 1'b1;
                end
            end
        end
    end

    assign o_list.load      = a_move;
    assign o_list.bytes     = l_b;
    assign o_list.cnt       = l_n;
    assign o_list.comp_last = r_a_last;

    // Advance escape state when the word moves on
    always_comb begin
        n_a_vld    = accept ? 1'b1 : (a_move ? 1'b0 : r_a_vld);
        n_at_start = r_at_start;
        n_hc       = r_hc;
        if (a_move) begin
            n_at_start = r_a_last;
            n_hc       = r_a_last ? HELD_NONE : hc_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_kind     <= KIND_PATH;
            r_at_start <= 1'b1;
            r_hc       <= HELD_NONE;
            r_hd       <= '0;
        end else begin
            r_a_vld    <= n_a_vld;
            r_at_start <= n_at_start;
            r_hc       <= n_hc;
            if (a_move) begin
                r_hd <= n_hd;
            end
            if (i_cfg_valid) begin
                r_kind <= i_cfg_component_kind;
            end
        end
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_byte <= i_in_byte;
            r_a_last <= i_in_last;
        end
    end

endmodule

/* design/upe_serial.sv */
module upe_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  upe_pkg::t_list i_list,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_component_end
);
    import upe_pkg::*;

    logic [LIST_DEPTH-1:0][7:0] r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_vld, n_vld;
    logic             r_comp_last;
    logic             is_end;
    logic             take;

    assign is_end          = (CNT_W'(r_idx) == (r_cnt - 1'b1));
    assign take            = r_vld && !i_stall;
    assign o_free          = !r_vld || (take && is_end);
    assign o_valid         = r_vld;
    assign o_out_byte      = r_buf[r_idx];
    assign o_run_last      = is_end;
    assign o_component_end = is_end && r_comp_last;

    // Step through the list one word per cycle while the receiver does not stall, reload when drained
    always_comb begin
        n_vld = r_vld;
        n_idx = r_idx;
        if (take) begin
            n_idx = r_idx + 1'b1;
        end
        if (i_list.load) begin
            n_vld = (i_list.cnt != '0);
            n_idx = '0;
        end else if (take && is_end) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else begin
            r_vld <= n_vld;
            r_idx <= n_idx;
        end
    end

    // Hold the list payload
    always_ff @(posedge i_clk) begin
        if (i_list.load) begin
            r_buf       <= i_list.bytes;
            r_cnt       <= i_list.cnt;
            r_comp_last <= i_list.comp_last;
        end
    end

endmodule

/* design/url_component_percent_encoder_unit.sv */
// Percent-encoder for one URL component (path, query or fragment).
// Input channel: i_valid / o_stall carry one raw byte (i_in_byte) and
// i_in_last, which closes the component and flushes any held escape bytes.
// Output channel: o_valid / i_stall carry one encoded byte (o_out_byte),
// o_run_last on the final byte caused by an input word, and o_component_end
// on the final byte of the component.
// Configuration: i_cfg_valid / o_cfg_ready write the component kind
// (0 path, 1 query, 2 fragment); write it only between components.
// An accepted byte waits in the input register, then loads into the output
// buffer that shows the first encoded byte. Throughput: one output byte per
// cycle while the receiver does not stall; an input word expands to up to
// 7 bytes (three for an escaped byte), none if it only extends a held escape.
// The single byte-wide output port sets this rate.
// Reset clears the kind to path, drops held escape bytes and empties both
// stages. While the receiver stalls, the output word holds, one input word
// waits in the input register, and then o_stall rises.
module url_component_percent_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_component_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_component_kind
);
    import upe_pkg::*;

    t_list list;
    logic  free;

    assign o_cfg_ready = 1'b1;

    upe_encode u_encode (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_in_byte            (i_in_byte),
        .i_in_last            (i_in_last),
        .i_cfg_valid          (i_cfg_valid && o_cfg_ready),
        .i_cfg_component_kind (i_cfg_component_kind),
        .i_free               (free),
        .o_list               (list)
    );

    upe_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_list          (list),
        .o_free          (free),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_component_end (o_component_end)
    );

endmodule

/* design/upe_checker.sv */
module upe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_component_end
);

    // Hold a stalled output word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte)
            && $stable(o_component_end))
        else $error("stalled output word changed");

    // Close a component only on the final byte of a word
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_component_end |-> o_run_last)
        else $error("component end without run end");

    // Come out of reset with an empty output stage
    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind url_component_percent_encoder_unit upe_checker u_upe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_out_byte      (o_out_byte),
    .o_run_last      (o_run_last),
    .o_component_end (o_component_end)
);

/* tb/upe_encode_checker.sv */
`timescale 1ns / 1ps

module upe_encode_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    input  logic       i_component_end,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_kind,
    output int         o_fail_count,
    output int         o_words_waiting
);
    import upe_pkg::*;

    localparam int MAX_WORDS_PER_ITEM = 7;
    localparam int MAX_REPORTS        = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       comp_end;
    } t_enc_word;

    t_enc_word  encoded_q[$];
    t_enc_word  item_words[$];
    logic [1:0] kind_r   = KIND_PATH;
    logic       first_r  = 1'b1;
    logic [1:0] held_r   = HELD_NONE;
    logic [7:0] digit_r  = 8'h00;
    int         fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // Print one line per mismatch, up to a cap, and count every one
    task automatic report_mismatch(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t encoder check: %s", $time, msg);
        end
    endtask

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        string digits;
        digits = "0123456789abcdef";
        return digits[n];
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Unreserved, sub-delims, ':' and '@'; '/' and '?' only in query and fragment
    function automatic bit keeps_char(input logic [7:0] c, input logic [1:0] kind);
        bit r;
        r = 1'b0;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
            r = 1'b1;
        end else begin
            case (c)
                "-", ".", "_", C_TILDE, "!", "$", "&", "'", "(", ")",
                "*", "+", ",", ";", "=", ":", "@": r = 1'b1;
                C_SLASH, C_QUES: r = (kind == KIND_QUERY) || (kind == KIND_FRAG);
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] ident_of(input logic [1:0] kind);
        logic [7:0] r;
        case (kind)
            KIND_QUERY: r = C_QUES;
            KIND_FRAG:  r = C_HASH;
            default:    r = C_SLASH;
        endcase
        return r;
    endfunction

    function automatic void put_word(input logic [7:0] c);
        if (item_words.size() < MAX_WORDS_PER_ITEM) begin
            item_words.push_back('{c, 1'b0, 1'b0});
        end
    endfunction

    function automatic void put_escape(input logic [7:0] c);
        put_word(C_PCT);
        put_word(hex_ascii(c[7:4]));
        put_word(hex_ascii(c[3:0]));
    endfunction

    // Handle one byte with no escape held
    function automatic void take_plain(input logic [7:0] c);
        if (keeps_char(c, kind_r)) begin
            put_word(c);
        end else if (c == C_PCT) begin
            held_r = HELD_PCT;
        end else begin
            put_escape(c);
        end
    endfunction

    // Advance the held-escape state by one byte
    function automatic void take_byte(input logic [7:0] c);
        case (held_r)
            HELD_PCT: begin
                if (is_hex_digit(c)) begin
                    digit_r = c;
                    held_r  = HELD_DIGIT;
                end else begin
                    held_r = HELD_NONE;
                    put_escape(C_PCT);
                    take_plain(c);
                end
            end
            HELD_DIGIT: begin
                held_r = HELD_NONE;
                if (is_hex_digit(c)) begin
                    put_word(C_PCT);
                    put_word(digit_r);
                    put_word(c);
                end else begin
                    put_escape(C_PCT);
                    take_plain(digit_r);
                    take_plain(c);
                end
            end
            default: begin
                held_r = HELD_NONE;
                take_plain(c);
            end
        endcase
    endfunction

    // Expand one accepted word into the encoded words it should produce
    function automatic void predict_encoding(input logic [7:0] c, input logic last);
        item_words.delete();
        if (first_r) begin
            first_r = 1'b0;
            held_r  = HELD_NONE;
            if (!last && c == ident_of(kind_r)) begin
                put_word(c);
            end else begin
                take_byte(c);
            end
        end else begin
            take_byte(c);
        end

        // Flush a cut-off escape at the end of the component
        if (last) begin
            if (held_r == HELD_PCT) begin
                put_escape(C_PCT);
            end else if (held_r == HELD_DIGIT) begin
                put_escape(C_PCT);
                put_word(digit_r);
            end
            held_r  = HELD_NONE;
            first_r = 1'b1;
        end

        if (item_words.size() > 0) begin
            item_words[item_words.size() - 1].run_last = 1'b1;
            item_words[item_words.size() - 1].comp_end = last;
        end
        foreach (item_words[i]) begin
            encoded_q.push_back(item_words[i]);
        end
    endfunction

    // Compare an accepted output word against the oldest expected one
    task automatic check_output();
        t_enc_word want;
        if (encoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word byte=%h run_last=%b end=%b",
                                      i_out_byte, i_run_last, i_component_end));
        end else begin
            want = encoded_q.pop_front();
            if (i_out_byte !== want.ch || i_run_last !== want.run_last ||
                i_component_end !== want.comp_end) begin
                report_mismatch($sformatf("got byte=%h run_last=%b end=%b, want %h %b %b",
                                          i_out_byte, i_run_last, i_component_end,
                                          want.ch, want.run_last, want.comp_end));
            end
        end
    endtask

    // Watch all three channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kind_r  = KIND_PATH;
            first_r = 1'b1;
            held_r  = HELD_NONE;
            digit_r = 8'h00;
            encoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_output();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                kind_r = i_cfg_kind;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_encoding(i_in_byte, i_in_last);
            end
        end
        o_words_waiting = encoded_q.size();
    end

endmodule

/* tb/tb_url_component_percent_encoder_unit.sv */
`timescale 1ns / 1ps

module tb_url_component_percent_encoder_unit;
    import upe_pkg::*;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam int         SEGMENT_LEN  = 38;
    localparam int         SETTLE_CYCLES = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       comp_end;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_kind;
    int         fail_count;
    int         words_waiting;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         words_sent    = 0;

    url_component_percent_encoder_unit dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (in_valid),
        .o_stall              (in_stall),
        .i_in_byte            (in_byte),
        .i_in_last            (in_last),
        .o_valid              (out_valid),
        .i_stall              (out_stall),
        .o_out_byte           (out_byte),
        .o_run_last           (run_last),
        .o_component_end      (comp_end),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_component_kind (cfg_kind)
    );

    upe_encode_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_in_last       (in_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_byte      (out_byte),
        .i_run_last      (run_last),
        .i_component_end (comp_end),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_kind      (cfg_kind),
        .o_fail_count    (fail_count),
        .o_words_waiting (words_waiting)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver stalls at random
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one word, idling first at random, and hold it until accepted
    task automatic send_word(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= last;
        do @(posedge clk); while (in_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], i == s.len() - 1);
        end
    endtask

    // Let every expected word drain, then the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (words_waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the component kind while the block is idle
    task automatic write_kind(input logic [1:0] kind);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_kind  <= kind;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One component of random length, mostly well-formed content
    task automatic send_random_component();
        logic [7:0] comp_q[$];
        logic [7:0] ident_set[3];
        string      safe;
        string      hexd;
        int         target;
        int         pick;
        ident_set = '{C_SLASH, C_QUES, C_HASH};
        safe      = "abmqyzABMQYZ0159-._~!$&'()*+,;=:@/?";
        hexd      = "0123456789abcdefABCDEF";
        target    = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
        if ($urandom_range(3) == 0) begin
            comp_q.push_back(ident_set[$urandom_range(2)]);
        end
        while (comp_q.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                comp_q.push_back(safe[$urandom_range(safe.len() - 1)]);
            end else if (pick < 60) begin
                comp_q.push_back(C_PCT);
                comp_q.push_back(hexd[$urandom_range(hexd.len() - 1)]);
                comp_q.push_back(hexd[$urandom_range(hexd.len() - 1)]);
            end else if (pick < 68) begin
                comp_q.push_back(C_PCT);
                comp_q.push_back(hexd[$urandom_range(hexd.len() - 1)]);
            end else if (pick < 74) begin
                comp_q.push_back(C_PCT);
            end else if (pick < 80) begin
                comp_q.push_back(ident_set[$urandom_range(2)]);
            end else begin
                comp_q.push_back(8'($urandom_range(255)));
            end
        end
        foreach (comp_q[i]) begin
            send_word(comp_q[i], i == comp_q.size() - 1);
        end
    endtask

    initial begin
        logic [1:0] kind_plan[6];
        int         seg_start;
        kind_plan = '{KIND_QUERY, KIND_FRAG, KIND_PATH, KIND_SPARE, KIND_FRAG, KIND_QUERY};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        cfg_valid = 1'b0;
        cfg_kind  = KIND_PATH;

        // Hold reset, then release it
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 50;

        // Directed: path identifiers, byte extremes, escapes
        write_kind(KIND_PATH);
        send_text("/a");
        send_text("/");
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h80, 1'b1);
        send_text("%aF%4g%%z");
        send_text("%");
        send_text("%4");

        // Query and fragment identifiers, '/' and '?' pass
        write_kind(KIND_QUERY);
        send_text("?/#");
        write_kind(KIND_FRAG);
        send_text("#/");

        // Kind change in the middle of a component
        send_word("b", 1'b0);
        write_kind(KIND_SPARE);
        send_word(C_SLASH, 1'b1);

        // Random segments across idle patterns and kinds
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 50;
                recv_idle_pct = 12;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_kind(kind_plan[seg]);
            seg_start = words_sent;
            while (words_sent - seg_start < SEGMENT_LEN) begin
                send_random_component();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
